[rtl/kelp_pkg.sv]
// Package with shared types, codes and default sizes of the kernel event latency profiler.
package kelp_pkg;

    // Default table and core sizes.
    localparam int DEF_EXCEPTION_COUNT = 32;
    localparam int DEF_INTERRUPT_COUNT = 16;
    localparam int DEF_SYSCALL_COUNT   = 64;
    localparam int DEF_CORE_COUNT      = 8;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Event codes carried in the action field.
    typedef enum logic [2:0] {
        ACT_ENTER_EXC = 3'd0,
        ACT_ENTER_IRQ = 3'd1,
        ACT_ENTER_SYS = 3'd2,
        ACT_LEAVE     = 3'd3,
        ACT_START     = 3'd4,
        ACT_READ      = 3'd5
    } t_action;

    // Controller states.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // One input item.
    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  core_id;
        logic [63:0] stamp;
        logic [7:0]  event_id;
        logic        thread_running;
        logic [6:0]  entry_index;
    } t_in;

    // One result item.
    typedef struct packed {
        logic [63:0] delta_cycles;
        logic [63:0] entry_count;
        logic [63:0] entry_total;
        logic [63:0] entry_shortest;
        logic [63:0] entry_longest;
        logic [63:0] kernel_cycles;
        logic [63:0] idle_cycles;
    } t_out;

    // One statistics table entry.
    typedef struct packed {
        logic [63:0] count;
        logic [63:0] sum;
        logic [63:0] min;
        logic [63:0] max;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_ctl;

endpackage

[rtl/kelp_ctrl.sv]
// Controller state machine of the kernel event latency profiler.
module kelp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_strobe,
    output kelp_pkg::t_ctl o_ctl
);
    import kelp_pkg::*;

    t_state r_state, n_state;
    logic   r_strobe;

    // State register and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= o_ctl.exec;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_ctl.load = 1'b0;
        o_ctl.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy   = (r_state == S_EXEC);
    assign o_strobe = r_strobe;

endmodule

[rtl/kelp_dpath.sv]
// Datapath of the kernel event latency profiler: core state, statistics memory and totals.
module kelp_dpath #(
    parameter int EXCEPTION_COUNT = kelp_pkg::DEF_EXCEPTION_COUNT,
    parameter int INTERRUPT_COUNT = kelp_pkg::DEF_INTERRUPT_COUNT,
    parameter int SYSCALL_COUNT   = kelp_pkg::DEF_SYSCALL_COUNT,
    parameter int CORE_COUNT      = kelp_pkg::DEF_CORE_COUNT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kelp_pkg::t_ctl i_ctl,
    input  kelp_pkg::t_in  i_item,
    output kelp_pkg::t_out o_result
);
    import kelp_pkg::*;

    localparam int TABLE_SIZE   = EXCEPTION_COUNT + INTERRUPT_COUNT + SYSCALL_COUNT + 1;
    localparam int UNKNOWN_SLOT = TABLE_SIZE - 1;
    localparam int IDX_W        = $clog2(TABLE_SIZE);
    localparam int CORE_W       = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
    localparam logic [IDX_W-1:0] UNKNOWN_IDX = IDX_W'(UNKNOWN_SLOT);

    // Architectural state.
    logic [63:0]           r_last [CORE_COUNT];
    logic [IDX_W-1:0]      r_open [CORE_COUNT];
    logic [TABLE_SIZE-1:0] r_valid;
    logic [63:0]           r_kernel;
    logic [63:0]           r_idle;
    t_entry                r_mem [TABLE_SIZE];

    // Item latched at acceptance.
    logic [2:0]        r_act;
    logic              r_core_ok;
    logic [CORE_W-1:0] r_cidx;
    logic [63:0]       r_stamp;
    logic [63:0]       r_delta;
    logic              r_run;
    logic [IDX_W-1:0]  r_map;
    logic [IDX_W-1:0]  r_addr;
    logic              r_ent_vld;
    t_entry            r_rd;
    t_out              r_res;

    logic              n_core_ok;
    logic [CORE_W-1:0] n_cidx;
    logic [63:0]       n_delta;
    logic [IDX_W-1:0]  n_map;
    logic [IDX_W-1:0]  n_addr;
    logic [IDX_W-1:0]  open_cur;

    // Map an event id of the given kind to its table index.
    function automatic logic [IDX_W-1:0] map_event(input logic [2:0] kind,
                                                   input logic [7:0] id);
        logic [IDX_W-1:0] idx;
        idx = UNKNOWN_IDX;
        if (kind == ACT_ENTER_EXC) begin
            if ({1'b0, id} < 9'(EXCEPTION_COUNT)) idx = IDX_W'(id);
        end else if (kind == ACT_ENTER_IRQ) begin
            if ({1'b0, id} < 9'(INTERRUPT_COUNT))
                idx = IDX_W'(EXCEPTION_COUNT) + IDX_W'(id);
        end else begin
            if ({1'b0, id} < 9'(SYSCALL_COUNT))
                idx = IDX_W'(EXCEPTION_COUNT + INTERRUPT_COUNT) + IDX_W'(id);
        end
        return idx;
    endfunction

    // Acceptance stage: elapsed cycles, mapped index and memory read address.
    always_comb begin
        n_core_ok = (int'(i_item.core_id) < CORE_COUNT);
        n_cidx    = CORE_W'(i_item.core_id);
        n_delta   = n_core_ok ? (i_item.stamp - r_last[n_cidx]) : 64'd0;
        open_cur  = n_core_ok ? r_open[n_cidx] : UNKNOWN_IDX;
        n_map     = map_event(i_item.action, i_item.event_id);
        if (i_item.action == ACT_LEAVE) begin
            n_addr = open_cur;
        end else if (int'(i_item.entry_index) < TABLE_SIZE) begin
            n_addr = IDX_W'(i_item.entry_index);
        end else begin
            n_addr = UNKNOWN_IDX;
        end
    end

    // Latch the item and read the addressed entry.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_act     <= i_item.action;
            r_core_ok <= n_core_ok;
            r_cidx    <= n_cidx;
            r_stamp   <= i_item.stamp;
            r_delta   <= n_delta;
            r_run     <= i_item.thread_running;
            r_map     <= n_map;
            r_addr    <= n_addr;
            r_ent_vld <= r_valid[n_addr];
            r_rd      <= r_mem[n_addr];
        end
    end

    // Execution stage: entry update, totals and result.
    t_entry cur, upd;
    logic   is_enter, is_leave, is_start, is_read;
    logic [63:0] n_kernel, n_idle;
    t_out   n_res;

    always_comb begin
        cur = r_ent_vld ? r_rd
                        : t_entry'{count: 64'd0, sum: 64'd0, min: ALL_ONES, max: 64'd0};
        upd.count = cur.count + 64'd1;
        upd.sum   = cur.sum + r_delta;
        upd.min   = (r_delta < cur.min) ? r_delta : cur.min;
        upd.max   = (r_delta > cur.max) ? r_delta : cur.max;

        is_enter = r_core_ok && (r_act == ACT_ENTER_EXC || r_act == ACT_ENTER_IRQ ||
                                 r_act == ACT_ENTER_SYS);
        is_leave = r_core_ok && (r_act == ACT_LEAVE);
        is_start = (r_act == ACT_START);
        is_read  = (r_act == ACT_READ);

        n_kernel = r_kernel;
        n_idle   = r_idle;
        n_res    = '0;
        if (is_enter) begin
            n_res.delta_cycles = r_delta;
            if (!r_run) n_idle = r_idle + r_delta;
        end else if (is_leave) begin
            n_res.delta_cycles   = r_delta;
            n_kernel             = r_kernel + r_delta;
            n_res.entry_count    = upd.count;
            n_res.entry_total    = upd.sum;
            n_res.entry_shortest = (upd.count == 64'd0) ? 64'd0 : upd.min;
            n_res.entry_longest  = upd.max;
        end else if (is_start) begin
            n_kernel = 64'd0;
            n_idle   = 64'd0;
        end else if (is_read) begin
            n_res.entry_count    = cur.count;
            n_res.entry_total    = cur.sum;
            n_res.entry_shortest = (cur.count == 64'd0) ? 64'd0 : cur.min;
            n_res.entry_longest  = cur.max;
        end
        n_res.kernel_cycles = n_kernel;
        n_res.idle_cycles   = n_idle;
    end

    // Statistics memory write-back on leave.
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && is_leave) begin
            r_mem[r_addr] <= upd;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_res <= n_res;
        end
    end

    // Core state, valid bits and totals.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_kernel <= 64'd0;
            r_idle   <= 64'd0;
            for (int c = 0; c < CORE_COUNT; c++) begin
                r_last[c] <= 64'd0;
                r_open[c] <= UNKNOWN_IDX;
            end
        end else if (i_ctl.exec) begin
            r_kernel <= n_kernel;
            r_idle   <= n_idle;
            if (is_enter) begin
                r_last[r_cidx] <= r_stamp;
                r_open[r_cidx] <= r_map;
            end else if (is_leave) begin
                r_last[r_cidx]  <= r_stamp;
                r_open[r_cidx]  <= UNKNOWN_IDX;
                r_valid[r_addr] <= 1'b1;
            end else if (is_start) begin
                r_valid <= '0;
                // Every core is seeded; only the issuing core opens the syscall.
                for (int c = 0; c < CORE_COUNT; c++) begin
                    r_last[c] <= r_stamp;
                    r_open[c] <= (r_core_ok && (c == int'(r_cidx))) ? r_map : UNKNOWN_IDX;
                end
            end
        end
    end

    assign o_result = r_res;

endmodule

[rtl/kernel_event_latency_profiler.sv]
// Top level of the kernel event latency profiler.
//
//  channel  | ports                       | direction | transfer
//  ---------+-----------------------------+-----------+-------------------------------
//  command  | start, busy, i_item         | in        | start high while busy is low
//  result   | o_strobe, o_result          | out       | one cycle per item, strobe high
//
// For each item, the accepting edge reads the core state and the statistics memory, and
// the execute cycle updates the entry and writes it back over the single memory port. The
// result is registered and shown in the cycle after the execute cycle, while the next item
// may be accepted. Reset is synchronous and active low and leaves all entries invalid. The
// receiver cannot stall; busy is high only during the execute cycle.
module kernel_event_latency_profiler #(
    parameter int EXCEPTION_COUNT = kelp_pkg::DEF_EXCEPTION_COUNT,
    parameter int INTERRUPT_COUNT = kelp_pkg::DEF_INTERRUPT_COUNT,
    parameter int SYSCALL_COUNT   = kelp_pkg::DEF_SYSCALL_COUNT,
    parameter int CORE_COUNT      = kelp_pkg::DEF_CORE_COUNT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  kelp_pkg::t_in  i_item,
    output logic           o_strobe,
    output kelp_pkg::t_out o_result
);
    import kelp_pkg::*;

    t_ctl ctl;

    // Sequencing of each item.
    kelp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_ctl    (ctl)
    );

    // State, statistics and result computation.
    kelp_dpath #(
        .EXCEPTION_COUNT (EXCEPTION_COUNT),
        .INTERRUPT_COUNT (INTERRUPT_COUNT),
        .SYSCALL_COUNT   (SYSCALL_COUNT),
        .CORE_COUNT      (CORE_COUNT)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

[rtl/kelp_checker.sv]
// Port-level checker of the kernel event latency profiler and its bind.
module kelp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input kelp_pkg::t_in  i_item,
    input logic           o_strobe,
    input kelp_pkg::t_out o_result
);
    import kelp_pkg::*;

    // An accepted item occupies exactly one execute cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    // Every execute cycle yields exactly one result in the following cycle.
    a_busy_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_strobe)
        else $error("no result after execute cycle");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result without a preceding item");

    // A start item clears both totals.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_START) |=> ##1
        (o_result.kernel_cycles == 64'd0 && o_result.idle_cycles == 64'd0))
        else $error("start did not clear totals");

endmodule

bind kernel_event_latency_profiler kelp_checker u_kelp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

[sim/kernel_event_latency_profiler_tb.sv]
// Self-checking testbench for the kernel event latency profiler: directed events, then random
// event streams, gapped or not, checked against a cycle-free predictor of the statistics.
module kernel_event_latency_profiler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kelp_pkg::*;

    localparam int EXC_N        = DEF_EXCEPTION_COUNT;
    localparam int IRQ_N        = DEF_INTERRUPT_COUNT;
    localparam int SYS_N        = DEF_SYSCALL_COUNT;
    localparam int CORE_N       = DEF_CORE_COUNT;
    localparam int TABLE_N      = EXC_N + IRQ_N + SYS_N + 1;
    localparam int UNKNOWN_SLOT = EXC_N + IRQ_N + SYS_N;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_CYCLES = 6;

    // Action codes that the block leaves unused.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_strobe;
    t_out o_result;

    kernel_event_latency_profiler u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Predicted statistics table, totals and per-core state.
    logic [63:0] tbl_count [TABLE_N];
    logic [63:0] tbl_sum   [TABLE_N];
    logic [63:0] tbl_min   [TABLE_N];
    logic [63:0] tbl_max   [TABLE_N];
    bit          tbl_valid [TABLE_N];
    logic [63:0] kernel_sum;
    logic [63:0] idle_sum;
    logic [63:0] core_stamp [CORE_N];
    int          core_slot  [CORE_N];

    // Expected results in arrival order.
    t_out awaited_stats [$];
    t_out stats_head;

    // Stimulus bookkeeping.
    logic [63:0] wall_clock;
    bit          in_kernel [CORE_N];
    int          items_sent;
    int          results_seen;
    int          mismatch_count;
    int          cycle_count;
    int          starts_sent;
    int          leaves_sent;

    always #2 i_clk = ~i_clk;

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_stats.size());
            $display("kernel_event_latency_profiler verification failed");
            $finish;
        end
    end

    // Table index for an enter event of the given kind.
    function automatic int slot_of(input logic [2:0] kind, input logic [7:0] id);
        if (kind == ACT_ENTER_EXC) begin
            if (id < EXC_N) return int'(id);
        end else if (kind == ACT_ENTER_IRQ) begin
            if (id < IRQ_N) return EXC_N + int'(id);
        end else begin
            if (id < SYS_N) return EXC_N + IRQ_N + int'(id);
        end
        return UNKNOWN_SLOT;
    endfunction

    // Copy one table entry into a result; invalid entries read as zero.
    function automatic void fill_entry(inout t_out r, input int slot);
        if (tbl_valid[slot]) begin
            r.entry_count    = tbl_count[slot];
            r.entry_total    = tbl_sum[slot];
            r.entry_shortest = (tbl_count[slot] == 64'd0) ? 64'd0 : tbl_min[slot];
            r.entry_longest  = tbl_max[slot];
        end
    endfunction

    // Apply one event to the predicted state and return the expected result.
    function automatic t_out profile_event(input t_in it);
        t_out        r;
        logic [63:0] delta;
        int          slot;
        r = '0;
        if (it.action <= ACT_LEAVE && it.core_id < CORE_N) begin
            delta = it.stamp - core_stamp[it.core_id];
            core_stamp[it.core_id] = it.stamp;
            r.delta_cycles = delta;
            if (it.action != ACT_LEAVE) begin
                core_slot[it.core_id] = slot_of(it.action, it.event_id);
                if (!it.thread_running) idle_sum += delta;
            end else begin
                slot = core_slot[it.core_id];
                kernel_sum += delta;
                if (!tbl_valid[slot]) begin
                    tbl_valid[slot] = 1'b1;
                    tbl_count[slot] = '0;
                    tbl_sum[slot]   = '0;
                    tbl_min[slot]   = ALL_ONES;
                    tbl_max[slot]   = '0;
                end
                tbl_count[slot] += 64'd1;
                tbl_sum[slot]   += delta;
                if (delta < tbl_min[slot]) tbl_min[slot] = delta;
                if (delta > tbl_max[slot]) tbl_max[slot] = delta;
                fill_entry(r, slot);
                core_slot[it.core_id] = UNKNOWN_SLOT;
            end
        end else if (it.action == ACT_START) begin
            for (int i = 0; i < TABLE_N; i++) tbl_valid[i] = 1'b0;
            kernel_sum = '0;
            idle_sum   = '0;
            for (int c = 0; c < CORE_N; c++) begin
                core_stamp[c] = it.stamp;
                core_slot[c]  = UNKNOWN_SLOT;
            end
            if (it.core_id < CORE_N) core_slot[it.core_id] = slot_of(ACT_ENTER_SYS, it.event_id);
        end else if (it.action == ACT_READ) begin
            fill_entry(r, (it.entry_index < TABLE_N) ? int'(it.entry_index) : UNKNOWN_SLOT);
        end
        r.kernel_cycles = kernel_sum;
        r.idle_cycles   = idle_sum;
        return r;
    endfunction

    // Print one mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h expected %h",
                                      results_seen, name, got, want));
    endtask

    // Compare every result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (awaited_stats.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          results_seen));
            end else begin
                stats_head = awaited_stats.pop_front();
                check_field("delta_cycles",   o_result.delta_cycles,   stats_head.delta_cycles);
                check_field("entry_count",    o_result.entry_count,    stats_head.entry_count);
                check_field("entry_total",    o_result.entry_total,    stats_head.entry_total);
                check_field("entry_shortest", o_result.entry_shortest,
                            stats_head.entry_shortest);
                check_field("entry_longest",  o_result.entry_longest,  stats_head.entry_longest);
                check_field("kernel_cycles",  o_result.kernel_cycles,  stats_head.kernel_cycles);
                check_field("idle_cycles",    o_result.idle_cycles,    stats_head.idle_cycles);
            end
            results_seen++;
        end
    end

    // Offer one item and hold it until the block takes it; start stays high on return.
    task automatic send_item(input t_in it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        awaited_stats.push_back(profile_event(it));
        items_sent++;
        if (it.action == ACT_START) starts_sent++;
        if (it.action == ACT_LEAVE) leaves_sent++;
    endtask

    // Sender gap: idle for a random number of cycles.
    task automatic idle_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Hold off until every expected result has been checked.
    task automatic drain_results();
        start <= 1'b0;
        while (awaited_stats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in make_item(input logic [2:0] act, input logic [2:0] core,
                                      input logic [63:0] stamp, input logic [7:0] id,
                                      input logic running, input logic [6:0] idx);
        t_in it;
        it.action         = act;
        it.core_id        = core;
        it.stamp          = stamp;
        it.event_id       = id;
        it.thread_running = running;
        it.entry_index    = idx;
        return it;
    endfunction

    // Advance the shared cycle counter; now and then jump or use a wild stamp.
    function automatic logic [63:0] next_stamp();
        if ($urandom_range(0, 39) == 0) wall_clock = {$urandom, $urandom};
        wall_clock += 64'($urandom_range(1, 3000));
        if ($urandom_range(0, 31) == 0) return {$urandom, $urandom};
        return wall_clock;
    endfunction

    // Event id for an enter of the given kind, mostly inside the table.
    function automatic logic [7:0] pick_id(input logic [2:0] kind);
        if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
        if (kind == ACT_ENTER_EXC) return 8'($urandom_range(0, EXC_N - 1));
        if (kind == ACT_ENTER_IRQ) return 8'($urandom_range(0, IRQ_N - 1));
        return 8'($urandom_range(0, SYS_N - 1));
    endfunction

    // Extremes, every action and each special case, one event at a time.
    task automatic test_directed_events();
        send_item(make_item(ACT_READ, 3'd0, 64'd0, 8'd0, 1'b0, 7'd0));
        send_item(make_item(ACT_READ, 3'd7, ALL_ONES, 8'hFF, 1'b1, 7'd127));
        send_item(make_item(ACT_START, 3'd2, 64'd1000, 8'd5, 1'b0, 7'd0));
        // Exception entered from idle, then left.
        send_item(make_item(ACT_ENTER_EXC, 3'd0, 64'd1100, 8'd3, 1'b0, 7'd0));
        send_item(make_item(ACT_LEAVE, 3'd0, 64'd1350, 8'd0, 1'b0, 7'd0));
        // Interrupt at the top of its range with a thread running.
        send_item(make_item(ACT_ENTER_IRQ, 3'd1, 64'd1400, 8'd15, 1'b1, 7'd0));
        send_item(make_item(ACT_LEAVE, 3'd1, 64'd1401, 8'd0, 1'b1, 7'd0));
        // Interrupt id out of range lands in the unknown slot.
        send_item(make_item(ACT_ENTER_IRQ, 3'd3, 64'd1500, 8'd200, 1'b0, 7'd0));
        send_item(make_item(ACT_LEAVE, 3'd3, 64'd1800, 8'd0, 1'b0, 7'd0));
        // Stamp of all ones and a wrapping difference.
        send_item(make_item(ACT_ENTER_SYS, 3'd4, ALL_ONES, 8'd63, 1'b0, 7'd0));
        send_item(make_item(ACT_LEAVE, 3'd4, 64'd5, 8'd0, 1'b0, 7'd0));
        // Leave of the syscall that start opened, and a leave with nothing open.
        send_item(make_item(ACT_LEAVE, 3'd2, 64'd2000, 8'd0, 1'b0, 7'd0));
        send_item(make_item(ACT_LEAVE, 3'd5, 64'd2100, 8'd0, 1'b0, 7'd0));
        // Exception id just past its range.
        send_item(make_item(ACT_ENTER_EXC, 3'd7, 64'd2200, 8'd32, 1'b0, 7'd0));
        send_item(make_item(ACT_LEAVE, 3'd7, 64'd2600, 8'd0, 1'b1, 7'd0));
        send_item(make_item(ACT_READ, 3'd0, 64'd0, 8'd0, 1'b0, 7'(UNKNOWN_SLOT)));
        send_item(make_item(ACT_READ, 3'd0, 64'd0, 8'd0, 1'b0, 7'(EXC_N + 15)));
        send_item(make_item(ACT_READ, 3'd0, 64'd0, 8'd0, 1'b0, 7'(TABLE_N)));
        // Unused actions change nothing.
        send_item(make_item(ACT_SPARE_LO, 3'd0, 64'd3000, 8'd1, 1'b0, 7'd3));
        send_item(make_item(ACT_SPARE_HI, 3'd6, ALL_ONES, 8'hFF, 1'b1, 7'd127));
        // Start with a syscall id out of range clears everything.
        send_item(make_item(ACT_START, 3'd6, 64'd0, 8'd255, 1'b1, 7'd0));
        send_item(make_item(ACT_READ, 3'd0, 64'd0, 8'd0, 1'b0, 7'd3));
        // Zero-length syscall gives a shortest time of zero.
        send_item(make_item(ACT_ENTER_SYS, 3'd6, 64'd0, 8'd0, 1'b0, 7'd0));
        send_item(make_item(ACT_LEAVE, 3'd6, 64'd0, 8'd0, 1'b0, 7'd0));
        send_item(make_item(ACT_READ, 3'd0, 64'd0, 8'd0, 1'b0, 7'(EXC_N + IRQ_N)));
    endtask

    // Mostly well-formed enter and leave pairs per core, with reads, starts and noise.
    task automatic test_random_events(input int n_items, input int idle_pct);
        t_in            it;
        int             roll;
        logic [2:0]     core;
        for (int k = 0; k < n_items; k++) begin
            idle_gap(idle_pct);
            roll = $urandom_range(0, 99);
            core = 3'($urandom_range(0, CORE_N - 1));
            it = make_item(3'($urandom_range(0, 7)), core, next_stamp(),
                           8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           7'($urandom_range(0, 127)));
            if (roll < 8) begin
                // Noise: every field random, including unused actions.
                it.stamp = {$urandom, $urandom};
            end else if (roll < 18) begin
                it.action = ACT_READ;
                if ($urandom_range(0, 1)) it.entry_index = 7'($urandom_range(0, UNKNOWN_SLOT));
            end else if (roll < 21) begin
                it.action = ACT_START;
                for (int c = 0; c < CORE_N; c++) in_kernel[c] = 1'b0;
                in_kernel[core] = 1'b1;
            end else if (in_kernel[core]) begin
                it.action = ACT_LEAVE;
                in_kernel[core] = 1'b0;
            end else begin
                it.action = 3'($urandom_range(ACT_ENTER_EXC, ACT_ENTER_SYS));
                it.event_id = pick_id(it.action);
                in_kernel[core] = 1'b1;
            end
            send_item(it);
            // Occasionally let the block run dry before continuing.
            if ($urandom_range(0, 49) == 0) drain_results();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        cycle_count = 0;
        items_sent = 0;
        results_seen = 0;
        mismatch_count = 0;
        starts_sent = 0;
        leaves_sent = 0;
        wall_clock = '0;
        kernel_sum = '0;
        idle_sum = '0;
        for (int i = 0; i < TABLE_N; i++) begin
            tbl_count[i] = '0;
            tbl_sum[i]   = '0;
            tbl_min[i]   = ALL_ONES;
            tbl_max[i]   = '0;
            tbl_valid[i] = 1'b0;
        end
        for (int c = 0; c < CORE_N; c++) begin
            core_stamp[c] = '0;
            core_slot[c]  = UNKNOWN_SLOT;
            in_kernel[c]  = 1'b0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_events();
        drain_results();
        test_random_events(100, 0);
        drain_results();
        test_random_events(100, 66);
        drain_results();
        test_random_events(100, 30);
        drain_results();
        test_random_events(100, 0);
        drain_results();

        if (awaited_stats.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_stats.size()));
        $display("Sent %0d events (%0d leaves, %0d starts), checked %0d results.",
                 items_sent, leaves_sent, starts_sent, results_seen);
        $display("Phases: directed corners, back-to-back, 66 and 30 percent sender gaps; "
                 , "%0d mismatches.", mismatch_count);
        if (mismatch_count == 0) begin
            $display("kernel_event_latency_profiler verification clean");
        end else begin
            $display("kernel_event_latency_profiler verification failed");
        end
        $finish;
    end

endmodule
